FILE: hdl/potq_pkg.sv
`default_nettype none

package potq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_LIST   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic list_next;
    } potq_cmd_t;

    typedef struct packed {
        logic out_last;
    } potq_sts_t;

endpackage

`default_nettype wire

FILE: hdl/priority_ordered_task_queue.sv
// channel   handshake              payload
// input     in_valid / in_ready    action, task_id, priority_req
// output    out_valid / out_ready  status, out_task_id, out_priority, last
//
// one request at a time: accept state, execute state, then the result register
// insert, pop and remove give a single result; list gives one per entry, or one when empty
// insert, pop and remove work on all cells in parallel in the execute cycle
// list reads one entry per output handshake through the result register
// reset clears the entry count and list index only; no clearing pass
`default_nettype none

module priority_ordered_task_queue
    import potq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] task_id,
    input  wire logic [7:0]  priority_req,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      out_task_id,
    output logic [7:0]       out_priority,
    output logic             last
);

    potq_cmd_t cmd;
    potq_sts_t sts;

    potq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    potq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .task_id      (task_id),
        .priority_req (priority_req),
        .status       (status),
        .out_task_id  (out_task_id),
        .out_priority (out_priority),
        .last         (last)
    );

endmodule

`default_nettype wire

FILE: hdl/potq_ctrl.sv
`default_nettype none

module potq_ctrl
    import potq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire potq_sts_t sts,
    output potq_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign cmd.load_in   = in_valid && in_ready;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.list_next = out_valid && out_ready && !sts.out_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready && sts.out_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> cmd.exec)
        else $error("accepted request not executed");

    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("execution gave no result");
`endif

endmodule

`default_nettype wire

FILE: hdl/potq_dp.sv
`default_nettype none

module potq_dp
    import potq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire potq_cmd_t   cmd,
    output potq_sts_t        sts,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] task_id,
    input  wire logic [7:0]  priority_req,
    output logic [1:0]       status,
    output logic [15:0]      out_task_id,
    output logic [7:0]       out_priority,
    output logic             last
);

    logic [1:0]       act_reg;
    logic [15:0]      id_in_reg;
    logic [7:0]       pri_in_reg;

    logic [15:0]      ids_reg [DEPTH];
    logic [7:0]       pris_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] lidx_reg;
    logic [CNT_W-1:0] lidx_next;

    logic [1:0]       status_reg;
    logic [15:0]      oid_reg;
    logic [7:0]       opri_reg;
    logic             last_reg;

    logic [DEPTH-1:0] vld;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] ge_prev;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] hit_prev;
    logic [15:0]      id_up [DEPTH];
    logic [7:0]       pri_up [DEPTH];
    logic [15:0]      id_dn [DEPTH];
    logic [7:0]       pri_dn [DEPTH];
    logic [15:0]      rm_id;
    logic [7:0]       rm_pri;
    logic             full;
    logic             empty;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign lidx_next = lidx_reg + CNT_W'(1);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            vld[i]   = (CNT_W'(i) < count_reg);
            ge[i]    = vld[i] && (pris_reg[i] >= pri_in_reg);
            match[i] = vld[i] && (ids_reg[i] == id_in_reg);
        end
        hit[0] = match[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            hit[i] = hit[i-1] | match[i];
        end
        ge_prev  = {ge[DEPTH-2:0], 1'b1};
        hit_prev = {hit[DEPTH-2:0], 1'b0};

        id_up[0]  = id_in_reg;
        pri_up[0] = pri_in_reg;
        for (int i = 1; i < DEPTH; i++)
        begin
            id_up[i]  = ids_reg[i-1];
            pri_up[i] = pris_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            id_dn[i]  = ids_reg[i+1];
            pri_dn[i] = pris_reg[i+1];
        end
        id_dn[DEPTH-1]  = ids_reg[DEPTH-1];
        pri_dn[DEPTH-1] = pris_reg[DEPTH-1];

        rm_id  = '0;
        rm_pri = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i] && !hit_prev[i])
            begin
                rm_id  = ids_reg[i];
                rm_pri = pris_reg[i];
            end
        end
    end

    // input request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg    <= action;
            id_in_reg  <= task_id;
            pri_in_reg <= priority_req;
        end
    end

    // entry cells
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (!full && !ge[i])
                        begin
                            if (ge_prev[i])
                            begin
                                ids_reg[i]  <= id_in_reg;
                                pris_reg[i] <= pri_in_reg;
                            end
                            else
                            begin
                                ids_reg[i]  <= id_up[i];
                                pris_reg[i] <= pri_up[i];
                            end
                        end
                    end
                    ACT_POP:
                    begin
                        ids_reg[i]  <= id_dn[i];
                        pris_reg[i] <= pri_dn[i];
                    end
                    ACT_REMOVE:
                    begin
                        if (hit[i])
                        begin
                            ids_reg[i]  <= id_dn[i];
                            pris_reg[i] <= pri_dn[i];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // count and list index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lidx_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            lidx_reg <= CNT_W'(1);
            case (act_reg)
                ACT_INSERT:
                begin
                    if (!full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ACT_POP:
                begin
                    if (!empty)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                ACT_REMOVE:
                begin
                    if (|match)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.list_next)
        begin
            lidx_reg <= lidx_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            last_reg <= 1'b1;
            case (act_reg)
                ACT_INSERT:
                begin
                    status_reg <= full ? ST_FULL : ST_OK;
                    oid_reg    <= id_in_reg;
                    opri_reg   <= pri_in_reg;
                end
                ACT_POP:
                begin
                    status_reg <= empty ? ST_EMPTY : ST_OK;
                    oid_reg    <= empty ? 16'd0 : ids_reg[0];
                    opri_reg   <= empty ? 8'd0 : pris_reg[0];
                end
                ACT_REMOVE:
                begin
                    if (empty)
                    begin
                        status_reg <= ST_EMPTY;
                        oid_reg    <= '0;
                        opri_reg   <= '0;
                    end
                    else if (|match)
                    begin
                        status_reg <= ST_OK;
                        oid_reg    <= rm_id;
                        opri_reg   <= rm_pri;
                    end
                    else
                    begin
                        status_reg <= ST_NOTFOUND;
                        oid_reg    <= id_in_reg;
                        opri_reg   <= '0;
                    end
                end
                default:
                begin
                    status_reg <= empty ? ST_EMPTY : ST_OK;
                    oid_reg    <= empty ? 16'd0 : ids_reg[0];
                    opri_reg   <= empty ? 8'd0 : pris_reg[0];
                    last_reg   <= (count_reg <= CNT_W'(1));
                end
            endcase
        end
        else if (cmd.list_next)
        begin
            status_reg <= ST_OK;
            oid_reg    <= ids_reg[lidx_reg[IDX_W-1:0]];
            opri_reg   <= pris_reg[lidx_reg[IDX_W-1:0]];
            last_reg   <= (lidx_next == count_reg);
        end
    end

    assign status       = status_reg;
    assign out_task_id  = oid_reg;
    assign out_priority = opri_reg;
    assign last         = last_reg;
    assign sts.out_last = last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("entry count moved outside execution");

    a_list_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_next |-> (lidx_reg < count_reg))
        else $error("list index past last entry");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
import potq_pkg::*;

typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
} task_entry_t;

typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [7:0]  prio;
    logic        last;
} task_response_t;

class task_queue_scoreboard;
    task_entry_t    held_tasks[$];
    task_response_t awaited_responses[$];
    int unsigned    failures;

    function new();
        failures = 0;
    endfunction

    function int outstanding();
        return awaited_responses.size();
    endfunction

    function void push_response(logic [1:0] st, logic [15:0] id, logic [7:0] pr, logic l);
        task_response_t r;
        r = {st, id, pr, l};
        awaited_responses.push_back(r);
    endfunction

    // sorted insert, pop, remove-by-id and list on the held tasks
    function void note_request(logic [1:0] act, logic [15:0] id, logic [7:0] pr);
        task_entry_t e;
        int pos;
        bit found;
        case (act)
            ACT_INSERT:
            begin
                if (held_tasks.size() >= DEPTH)
                begin
                    push_response(ST_FULL, id, pr, 1'b1);
                end
                else
                begin
                    pos = 0;
                    while (pos < held_tasks.size() && held_tasks[pos].prio >= pr)
                        pos++;
                    e = {id, pr};
                    held_tasks.insert(pos, e);
                    push_response(ST_OK, id, pr, 1'b1);
                end
            end
            ACT_POP:
            begin
                if (held_tasks.size() == 0)
                begin
                    push_response(ST_EMPTY, 16'h0000, 8'h00, 1'b1);
                end
                else
                begin
                    e = held_tasks.pop_front();
                    push_response(ST_OK, e.id, e.prio, 1'b1);
                end
            end
            ACT_REMOVE:
            begin
                if (held_tasks.size() == 0)
                begin
                    push_response(ST_EMPTY, 16'h0000, 8'h00, 1'b1);
                end
                else
                begin
                    found = 1'b0;
                    pos = 0;
                    while (!found && pos < held_tasks.size())
                    begin
                        if (held_tasks[pos].id == id)
                            found = 1'b1;
                        else
                            pos++;
                    end
                    if (found)
                    begin
                        e = held_tasks[pos];
                        held_tasks.delete(pos);
                        push_response(ST_OK, e.id, e.prio, 1'b1);
                    end
                    else
                    begin
                        push_response(ST_NOTFOUND, id, 8'h00, 1'b1);
                    end
                end
            end
            default:
            begin
                if (held_tasks.size() == 0)
                begin
                    push_response(ST_EMPTY, 16'h0000, 8'h00, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < held_tasks.size(); i++)
                        push_response(ST_OK, held_tasks[i].id, held_tasks[i].prio,
                                      i == held_tasks.size() - 1);
                end
            end
        endcase
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                     want_v, got_v);
        end
    endfunction

    function void check_response(logic [1:0] st, logic [15:0] id, logic [7:0] pr, logic l);
        task_response_t want;
        if (awaited_responses.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected response, expected none, actual status %0h id %0h prio %0h last %0h",
                     $realtime, st, id, pr, l);
            return;
        end
        want = awaited_responses.pop_front();
        compare_field("status", 16'(want.status), 16'(st));
        compare_field("out_task_id", want.id, id);
        compare_field("out_priority", 16'(want.prio), 16'(pr));
        compare_field("last", 16'(want.last), 16'(l));
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE      = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] out_task_id;
    logic [7:0]  out_priority;
    logic        last;

    task_queue_scoreboard sb;
    logic [15:0]          id_pool [0:POOL_SIZE-1];
    bit                   bursts_on;
    int                   stall_left;
    int unsigned          quiet_cycles = 0;

    priority_ordered_task_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .task_id      (task_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_task_id  (out_task_id),
        .out_priority (out_priority),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(status, out_task_id, out_priority, last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] act, input logic [15:0] id,
                                input logic [7:0] pr);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        task_id      <= id;
        priority_req <= pr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(act, id, pr);
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int w_ins, input int w_pop,
                             input int w_rem);
        int          roll;
        logic [1:0]  act;
        logic [15:0] id;
        logic [7:0]  pr;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < w_ins)
                act = ACT_INSERT;
            else if (roll < w_ins + w_pop)
                act = ACT_POP;
            else if (roll < w_ins + w_pop + w_rem)
                act = ACT_REMOVE;
            else
                act = ACT_LIST;
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : id_pool[$urandom_range(0, POOL_SIZE - 1)];
            pr = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            send_request(act, id, pr);
        end
    endtask

    initial
    begin
        in_valid     = 1'b0;
        action       = ACT_INSERT;
        task_id      = 16'h0000;
        priority_req = 8'h00;
        out_ready    = 1'b0;
        rst_n        = 1'b0;
        bursts_on    = 1'b1;
        stall_left   = 0;
        sb = new();
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = 16'($urandom);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue cases
        send_request(ACT_POP, 16'hA5A5, 8'h5A);
        send_request(ACT_REMOVE, 16'h1234, 8'hFF);
        send_request(ACT_LIST, 16'hFFFF, 8'hFF);

        // field extremes and equal priorities
        send_request(ACT_INSERT, 16'hFFFF, 8'hFF);
        send_request(ACT_INSERT, 16'h0000, 8'h00);
        send_request(ACT_INSERT, 16'h1234, 8'h80);
        send_request(ACT_INSERT, 16'h5678, 8'h80);
        send_request(ACT_LIST, 16'h0000, 8'h00);
        send_request(ACT_REMOVE, 16'hBEEF, 8'h00);
        send_request(ACT_REMOVE, 16'h5678, 8'h3C);
        send_request(ACT_POP, 16'hFFFF, 8'hFF);

        // fill up, then insert into a full queue
        for (int k = 0; k < 14; k++)
            send_request(ACT_INSERT, 16'h0100 + 16'(k % 5), 8'(k % 3) * 8'd100);
        send_request(ACT_INSERT, 16'hC3C3, 8'hFF);
        send_request(ACT_LIST, 16'h0000, 8'h00);
        pause_until_drained();

        run_phase(50, 60, 10, 15);
        pause_until_drained();
        run_phase(50, 10, 45, 30);
        pause_until_drained();
        run_phase(50, 35, 25, 25);
        pause_until_drained();
        bursts_on = 1'b0;
        run_phase(45, 40, 20, 25);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
